[rtl/tmm_pkg.sv]
// Shared types and constants for the int8 tile matrix-multiply block.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package tmm_pkg;

  localparam int unsigned AccW = 32;

  localparam logic [1:0] KIND_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_ACT    = 2'd1;
  localparam logic [1:0] KIND_ACC    = 2'd2;
  localparam logic [1:0] KIND_RUN    = 2'd3;

  localparam logic [1:0] CFG_ROWS  = 2'd0;
  localparam logic [1:0] CFG_COLS  = 2'd1;
  localparam logic [1:0] CFG_INNER = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [6:0]         elem_index;
    logic signed [31:0] elem_value;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]         out_index;
    logic signed [31:0] out_value;
    logic               last;
  } out_beat_t;

endpackage

[rtl/int8_tile_matmul_accumulate.sv]
// Top level of the int8 tile matrix-multiply-accumulate block.
// Depends on tmm_pkg and tmm_cell.
//
// Load beats (weight, activation, accumulator preload) are taken one per cycle while
// the block is idle and produce no output. A run beat computes, row by row, the
// products W[m][k]*A[k][n] with one 8x8 multiplier feeding a ring of N partial-sum
// cells: one product enters the ring per cycle, and after the last product of a row
// the pipeline drains. The row's N sums are then added to the stored accumulators,
// one result at a time (registered accumulator read, then add and write-back), held
// while the consumer stalls. The input side stays closed until the last result has
// been placed in the output register.
// Accumulators read as zero after reset through per-entry valid bits; no clearing pass.
module int8_tile_matmul_accumulate #(
  parameter int unsigned MAX_ROWS  = 8,
  parameter int unsigned MAX_COLS  = 8,
  parameter int unsigned MAX_INNER = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [4:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tmm_pkg::in_beat_t    in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tmm_pkg::out_beat_t   out_beat_o
);

  localparam int unsigned WDepth = MAX_ROWS * MAX_INNER;
  localparam int unsigned ADepth = MAX_INNER * MAX_COLS;
  localparam int unsigned ODepth = MAX_ROWS * MAX_COLS;
  localparam int unsigned WAW = (WDepth > 1) ? $clog2(WDepth) : 1;
  localparam int unsigned AAW = (ADepth > 1) ? $clog2(ADepth) : 1;
  localparam int unsigned OAW = (ODepth > 1) ? $clog2(ODepth) : 1;
  localparam int unsigned CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_ERD   = 3'd3;
  localparam logic [2:0] ST_EADD  = 3'd4;

  // Configuration registers, kept raw; the sizes below are the clamped views.
  logic [3:0] rows_q, cols_q;
  logic [4:0] inner_q;
  logic [3:0] m_sz, n_sz;
  logic [8:0] k_sz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= 4'd8;
      cols_q  <= 4'd8;
      inner_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tmm_pkg::CFG_ROWS:  rows_q  <= cfg_data_i[3:0];
        tmm_pkg::CFG_COLS:  cols_q  <= cfg_data_i[3:0];
        tmm_pkg::CFG_INNER: inner_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    m_sz = (rows_q == 4'd0) ? 4'd1 : ((rows_q > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : rows_q);
    n_sz = (cols_q == 4'd0) ? 4'd1 : ((cols_q > 4'(MAX_COLS)) ? 4'(MAX_COLS) : cols_q);
    k_sz = (inner_q == 5'd0) ? 9'd1 :
           ((9'(inner_q) > 9'(MAX_INNER)) ? 9'(MAX_INNER) : 9'(inner_q));
  end

  // Sequencer state and counters.
  logic [2:0]     state_q, state_d;
  logic [3:0]     m_q, m_d, n_q, n_d;
  logic [8:0]     k_q, k_d;
  logic [WAW-1:0] w_row_q, w_row_d;
  logic [AAW-1:0] a_row_q, a_row_d;
  logic [OAW-1:0] o_base_q, o_base_d;

  logic in_fire, out_free, emit_go, row_end, last_res;
  logic [12:0] mk_sz, kn_sz;
  logic [7:0]  mn_sz;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;
  assign emit_go    = (state_q == ST_EADD) && out_free;
  assign row_end    = (n_q == n_sz - 4'd1);
  assign last_res   = row_end && (m_q == m_sz - 4'd1);
  assign mk_sz      = 13'(m_sz) * 13'(k_sz);
  assign kn_sz      = 13'(k_sz) * 13'(n_sz);
  assign mn_sz      = 8'(m_sz) * 8'(n_sz);

  // Operand and accumulator stores.
  logic [7:0]               w_mem [WDepth];
  logic [7:0]               a_mem [ADepth];
  logic [tmm_pkg::AccW-1:0] acc_mem [ODepth];
  logic [ODepth-1:0]        acc_vld_q;

  logic [WAW-1:0] w_addr;
  logic [AAW-1:0] a_addr;
  logic [OAW-1:0] o_addr, acc_waddr;
  logic [7:0]     w_rd_q, a_rd_q;
  logic [tmm_pkg::AccW-1:0] acc_rd_q, acc_wdata, new_sum;
  logic           acc_ok_q, acc_we;

  assign w_addr = w_row_q + WAW'(k_q);
  assign a_addr = a_row_q + AAW'(n_q);
  assign o_addr = o_base_q + OAW'(n_q);

  always_ff @(posedge clk_i) begin
    if (in_fire && in_beat_i.kind == tmm_pkg::KIND_WEIGHT &&
        13'(in_beat_i.elem_index) < mk_sz) begin
      w_mem[WAW'(in_beat_i.elem_index)] <= in_beat_i.elem_value[7:0];
    end
    if (in_fire && in_beat_i.kind == tmm_pkg::KIND_ACT &&
        13'(in_beat_i.elem_index) < kn_sz) begin
      a_mem[AAW'(in_beat_i.elem_index)] <= in_beat_i.elem_value[7:0];
    end
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    w_rd_q   <= w_mem[w_addr];
    a_rd_q   <= a_mem[a_addr];
    acc_rd_q <= acc_mem[o_addr];
    acc_ok_q <= acc_vld_q[o_addr];
  end

  // The write port is shared: preloads only happen while idle, write-backs only in a run.
  always_comb begin
    acc_we    = emit_go;
    acc_waddr = o_addr;
    acc_wdata = new_sum;
    if (in_fire && in_beat_i.kind == tmm_pkg::KIND_ACC &&
        8'(in_beat_i.elem_index) < mn_sz) begin
      acc_we    = 1'b1;
      acc_waddr = OAW'(in_beat_i.elem_index);
      acc_wdata = in_beat_i.elem_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= '0;
    end else if (acc_we) begin
      acc_vld_q[acc_waddr] <= 1'b1;
    end
  end

  // Multiply pipeline: read stage, product stage, then the ring.
  logic s1_vld_q, s1_k0_q, s2_vld_q, s2_k0_q;
  logic signed [15:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= (state_q == ST_MAC);
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_k0_q <= (k_q == 9'd0);
    s2_k0_q <= s1_k0_q;
    prod_q  <= $signed(w_rd_q) * $signed(a_rd_q);
  end

  // Ring of partial-sum cells; the tap is the cell at position N-1.
  logic [tmm_pkg::AccW-1:0] cell_sum [MAX_COLS];
  logic [tmm_pkg::AccW-1:0] tap, head_in, head_add;
  logic                     ring_shift;

  assign tap        = cell_sum[CIW'(n_sz - 4'd1)];
  assign ring_shift = s2_vld_q || emit_go;
  assign head_in    = (s2_vld_q && s2_k0_q) ? '0 : tap;
  assign head_add   = s2_vld_q ? tmm_pkg::AccW'(prod_q) : '0;
  assign new_sum    = (acc_ok_q ? acc_rd_q : '0) + tap;

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
    tmm_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ring_shift),
      .in_i    ((c == 0) ? head_in : cell_sum[(c == 0) ? 0 : c - 1]),
      .add_i   ((c == 0) ? head_add : '0),
      .sum_o   (cell_sum[c])
    );
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    m_d      = m_q;
    n_d      = n_q;
    k_d      = k_q;
    w_row_d  = w_row_q;
    a_row_d  = a_row_q;
    o_base_d = o_base_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_beat_i.kind == tmm_pkg::KIND_RUN) begin
          state_d  = ST_MAC;
          m_d      = '0;
          n_d      = '0;
          k_d      = '0;
          w_row_d  = '0;
          a_row_d  = '0;
          o_base_d = '0;
        end
      end
      ST_MAC: begin
        if (row_end) begin
          n_d     = '0;
          a_row_d = a_row_q + AAW'(n_sz);
          k_d     = k_q + 9'd1;
          if (k_q == k_sz - 9'd1) begin
            k_d     = '0;
            a_row_d = '0;
            state_d = ST_DRAIN;
          end
        end else begin
          n_d = n_q + 4'd1;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = ST_ERD;
        end
      end
      ST_ERD: begin
        state_d = ST_EADD;
      end
      ST_EADD: begin
        if (out_free) begin
          if (!row_end) begin
            n_d     = n_q + 4'd1;
            state_d = ST_ERD;
          end else if (last_res) begin
            state_d = ST_IDLE;
          end else begin
            n_d      = '0;
            m_d      = m_q + 4'd1;
            w_row_d  = w_row_q + WAW'(k_sz);
            o_base_d = o_base_q + OAW'(n_sz);
            state_d  = ST_MAC;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      m_q      <= '0;
      n_q      <= '0;
      k_q      <= '0;
      w_row_q  <= '0;
      a_row_q  <= '0;
      o_base_q <= '0;
    end else begin
      state_q  <= state_d;
      m_q      <= m_d;
      n_q      <= n_d;
      k_q      <= k_d;
      w_row_q  <= w_row_d;
      a_row_q  <= a_row_d;
      o_base_q <= o_base_d;
    end
  end

  // Output register.
  logic               out_vld_q;
  tmm_pkg::out_beat_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit_go) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_q.out_index <= 6'(o_addr);
      out_q.out_value <= new_sum;
      out_q.last      <= last_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_q;

`ifndef NO_ASSERTIONS
  // The multiply pipeline must be empty before the ring is rotated for emission.
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ERD || state_q == ST_EADD) |-> (!s1_vld_q && !s2_vld_q))
    else $error("ring rotated while products are in flight");

  // Counters stay inside the configured tile during a run.
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (n_q < n_sz && m_q < m_sz && k_q < k_sz))
    else $error("tile counter out of range");

  // Emitting the last result closes the run.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && last_res) |=> (state_q == ST_IDLE && out_beat_o.last))
    else $error("run did not end after its last result");
`endif

endmodule

[rtl/tmm_cell.sv]
// One partial-sum cell of the column ring: adds an operand to its neighbor's value.
// Depends on tmm_pkg for the accumulator width.
module tmm_cell (
  input  logic                     clk_i,
  input  logic                     shift_i,
  input  logic [tmm_pkg::AccW-1:0] in_i,
  input  logic [tmm_pkg::AccW-1:0] add_i,
  output logic [tmm_pkg::AccW-1:0] sum_o
);

  logic [tmm_pkg::AccW-1:0] sum_d, sum_q;

  assign sum_d = in_i + add_i;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule
